FILE: rtl/teq_pkg.sv
`default_nettype none
package teq_pkg;
  localparam int unsigned TimeW = 48;
  localparam int unsigned PayW  = 39;
  localparam int unsigned OrdW  = 8;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    CmdSched = 2'd0,
    CmdTick  = 2'd1,
    CmdIdle  = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StZero   = 2'd2,
    StHalted = 2'd3
  } status_e;

  localparam logic [2:0] KindTimer = 3'd0;
  localparam logic CfgSysTick  = 1'b0;
  localparam logic CfgUserTick = 1'b1;

  typedef struct packed {
    logic [TimeW-1:0] due;
    logic [PayW-1:0]  pay;
    logic [OrdW-1:0]  ord;
  } entry_t;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: rtl/timed_event_queue.sv
`default_nettype none
// Timed event queue. Pending events live in a QUEUE_DEPTH-entry memory
// with one registered read port; valid bits sit in flip-flops. An item
// starts with a scan that reads each entry once to find the earliest due
// event, the first free entry, the count, and the tie rank for a schedule
// (a halted block, a none item and a zero-delay schedule skip the scan).
// A schedule then writes one entry if one is free. Tick and idle fire one
// event per scan, and each fired event costs another scan, a decide and a
// fire step. Each result is a beat on the output channel held in an output
// register, and the input stays stalled until the final beat has been
// taken. Ties at equal due time fire in schedule order. Times saturate at
// 2^48-1. After an idle on an empty queue, or on a lone timer event, the
// block halts and answers every item with status halted.
module timed_event_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,
  input  wire [7:0]   cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire [1:0]   cmd_i,
  input  wire [19:0]  delay_i,
  input  wire [2:0]   kind_i,
  input  wire [3:0]   handler_id_i,
  input  wire [31:0]  argument_i,
  input  wire         user_mode_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        event_fired_o,
  output logic [2:0]  fired_kind_o,
  output logic [3:0]  fired_handler_o,
  output logic [31:0] fired_argument_o,
  output logic [47:0] fire_time_o,
  output logic [1:0]  status_o,
  output logic [47:0] now_time_o,
  output logic [47:0] idle_time_o,
  output logic        last_o
);
  import teq_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    SIdle, SScan, SDecide, SEmit, SFire
  } state_e;

  state_e state_q;
  logic [7:0] sys_tick_q, user_tick_q;
  logic [TimeW-1:0] now_q, idle_q;
  logic halted_q;
  logic [7:0] icount_q;
  logic [QUEUE_DEPTH-1:0] valid_q;

  // latched item
  cmd_e cmd_q;
  logic [19:0] delay_q;
  logic [PayW-1:0] pay_q;
  logic [TimeW-1:0] due_new_q;
  logic idle_mode_q;   // lone-timer rule applies
  logic first_q;       // first scan of an item

  // scan
  logic [CW-1:0] ridx_q;     // read address counter
  logic rd_pend_q;
  logic [AW-1:0] pidx_q;     // index of data now on rdata
  logic best_vld_q;
  logic [AW-1:0] best_idx_q;
  entry_t best_q;
  logic free_vld_q;
  logic [AW-1:0] free_idx_q;
  logic [CW-1:0] cnt_q;
  logic [OrdW-1:0] ord_q;

  // memory port
  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rdata;

  teq_store #(.Depth(QUEUE_DEPTH), .AW(AW)) u_store (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign raddr = ridx_q[AW-1:0];
  assign cfg_ready_o = (state_q == SIdle) && !out_valid_o;
  assign in_stall_o = !((state_q == SIdle) && !out_valid_o);

  wire out_free = !out_valid_o || !out_stall_i;
  wire in_acc = in_valid_i && !in_stall_o;

  // a freshly read entry beats the best so far
  wire cand_v = rd_pend_q && valid_q[pidx_q];
  wire better = !best_vld_q || (rdata.due < best_q.due) ||
                (rdata.due == best_q.due && rdata.ord < best_q.ord);

  // while idling, hold back a timer event that is the only one left
  wire lone_hold = idle_mode_q && cnt_q == CW'(1) && best_q.pay[PayW-1 -: 3] == KindTimer;
  wire fire_ok = best_q.due <= now_q && !halted_q && !lone_hold;
  // a new beat enters the output register this cycle
  wire beat_load = out_free && (state_q == SEmit || (state_q == SFire && fire_ok));

  always_comb begin
    we = 1'b0;
    waddr = free_idx_q;
    wdata.due = due_new_q;
    wdata.pay = pay_q;
    wdata.ord = ord_q;
    if (state_q == SDecide && cmd_q == CmdSched && delay_q != '0 && free_vld_q &&
        !halted_q) we = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      sys_tick_q <= 8'd10;
      user_tick_q <= 8'd1;
      now_q <= '0;
      idle_q <= '0;
      halted_q <= 1'b0;
      icount_q <= '0;
      valid_q <= '0;
      out_valid_o <= 1'b0;
      cmd_q <= CmdNone;
      rd_pend_q <= 1'b0;
      ridx_q <= '0;
      idle_mode_q <= 1'b0;
      first_q <= 1'b0;
      best_vld_q <= 1'b0;
      free_vld_q <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i && !beat_load) out_valid_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgSysTick) sys_tick_q <= cfg_data_i;
        else user_tick_q <= cfg_data_i;
      end
      case (state_q)
        SIdle: begin
          if (in_acc) begin
            cmd_q <= cmd_e'(cmd_i);
            delay_q <= delay_i;
            pay_q <= {kind_i, handler_id_i, argument_i};
            due_new_q <= sat_add(now_q, {{(TimeW-20){1'b0}}, delay_i});
            idle_mode_q <= (cmd_e'(cmd_i) == CmdIdle);
            first_q <= 1'b1;
            if (!halted_q && cmd_e'(cmd_i) == CmdTick)
              now_q <= sat_add(now_q, {40'd0, user_mode_i ? user_tick_q : sys_tick_q});
            if (halted_q || cmd_e'(cmd_i) == CmdNone ||
                (cmd_e'(cmd_i) == CmdSched && delay_i == '0)) begin
              state_q <= SDecide;
            end else begin
              state_q <= SScan;
              ridx_q <= '0;
              rd_pend_q <= 1'b0;
              best_vld_q <= 1'b0;
              free_vld_q <= 1'b0;
              cnt_q <= '0;
              ord_q <= '0;
            end
          end
        end
        SScan: begin
          // issue reads, fold the entry read in the previous cycle
          if (ridx_q < CW'(QUEUE_DEPTH)) begin
            pidx_q <= ridx_q[AW-1:0];
            rd_pend_q <= 1'b1;
            ridx_q <= ridx_q + 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
          end
          if (rd_pend_q) begin
            if (cand_v) begin
              cnt_q <= cnt_q + 1'b1;
              if (better) begin
                best_vld_q <= 1'b1;
                best_idx_q <= pidx_q;
                best_q <= rdata;
              end
              if (rdata.due == due_new_q && rdata.ord + 1'b1 > ord_q)
                ord_q <= rdata.ord + 1'b1;
            end else if (!free_vld_q) begin
              free_vld_q <= 1'b1;
              free_idx_q <= pidx_q;
            end
          end
          if (rd_pend_q && ridx_q == CW'(QUEUE_DEPTH)) state_q <= SDecide;
        end
        SDecide: begin
          state_q <= SEmit;
          if (!halted_q && cmd_q == CmdSched && delay_q != '0 && free_vld_q) begin
            valid_q[free_idx_q] <= 1'b1;
            if (icount_q != 8'hFF) icount_q <= icount_q + 1'b1;
          end
          if (!halted_q && cmd_q == CmdIdle && first_q) begin
            if (!best_vld_q) begin
              halted_q <= 1'b1;
            end else begin
              if (best_q.due > now_q) begin
                idle_q <= sat_add(idle_q, best_q.due - now_q);
                now_q <= best_q.due;
              end
              if (cnt_q == CW'(1) && best_q.pay[PayW-1 -: 3] == KindTimer)
                halted_q <= 1'b1;
            end
          end
          if (!halted_q && (cmd_q == CmdTick || cmd_q == CmdIdle) && best_vld_q) begin
            // may fire; checked in SFire with updated now
            state_q <= SFire;
          end
          first_q <= 1'b0;
        end
        SFire: begin
          if (fire_ok) begin
            if (out_free) begin
              out_valid_o <= 1'b1;
              event_fired_o <= 1'b1;
              {fired_kind_o, fired_handler_o, fired_argument_o} <= best_q.pay;
              fire_time_o <= best_q.due;
              status_o <= StOk;
              now_time_o <= now_q;
              idle_time_o <= idle_q;
              last_o <= 1'b0;
              valid_q[best_idx_q] <= 1'b0;
              state_q <= SScan;
              ridx_q <= '0;
              rd_pend_q <= 1'b0;
              best_vld_q <= 1'b0;
              free_vld_q <= 1'b0;
              cnt_q <= '0;
            end
          end else begin
            state_q <= SEmit;
          end
        end
        SEmit: begin
          if (out_free) begin
            out_valid_o <= 1'b1;
            event_fired_o <= 1'b0;
            fired_kind_o <= '0;
            fired_handler_o <= '0;
            fired_argument_o <= '0;
            fire_time_o <= '0;
            if (halted_q) status_o <= StHalted;
            else if (cmd_q == CmdSched && delay_q == '0) status_o <= StZero;
            else if (cmd_q == CmdSched && !free_vld_q) status_o <= StFull;
            else status_o <= StOk;
            now_time_o <= now_q;
            idle_time_o <= idle_q;
            last_o <= 1'b1;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // the final beat of an item carries no event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> !event_fired_o) else $error("last beat fired");
  // no item taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !out_valid_o) else $error("accept with pending beat");
  // fired event is never in the future
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_fired_o |-> fire_time_o <= now_time_o)
    else $error("early fire");
endmodule
`default_nettype wire

FILE: rtl/teq_store.sv
`default_nettype none
// Entry memory: one write port, one read port, registered read data.
module teq_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AW    = 4
) (
  input  wire                 clk_i,
  input  wire                 we_i,
  input  wire [AW-1:0]        waddr_i,
  input  teq_pkg::entry_t     wdata_i,
  input  wire [AW-1:0]        raddr_i,
  output teq_pkg::entry_t     rdata_o
);
  import teq_pkg::*;
  entry_t mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

FILE: tb/sv/timed_event_queue_checker.sv
`timescale 1ns / 100ps
// Watches the item, result and register channels, tracks the event store
// and compares every result beat against the predicted one.
module timed_event_queue_checker
  import teq_pkg::*;
#(
  parameter int unsigned Depth = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  input  wire         cfg_ready_i,
  input  wire         cfg_index_i,
  input  wire [7:0]   cfg_data_i,
  input  wire         in_valid_i,
  input  wire         in_stall_i,
  input  wire [1:0]   cmd_i,
  input  wire [19:0]  delay_i,
  input  wire [2:0]   kind_i,
  input  wire [3:0]   handler_id_i,
  input  wire [31:0]  argument_i,
  input  wire         user_mode_i,
  input  wire         out_valid_i,
  input  wire         out_stall_i,
  input  wire         event_fired_i,
  input  wire [2:0]   fired_kind_i,
  input  wire [3:0]   fired_handler_i,
  input  wire [31:0]  fired_argument_i,
  input  wire [47:0]  fire_time_i,
  input  wire [1:0]   status_i,
  input  wire [47:0]  now_time_i,
  input  wire [47:0]  idle_time_i,
  input  wire         last_i,
  output int          mismatches_o,
  output int          beats_owed_o,
  output int          events_held_o,
  output logic        lone_timer_o,
  output logic        halted_o
);

  typedef struct packed {
    logic        fired;
    logic [2:0]  kind;
    logic [3:0]  hnd;
    logic [31:0] arg;
    logic [47:0] ftime;
    logic [1:0]  st;
    logic [47:0] now;
    logic [47:0] idle;
    logic        last;
  } beat_t;

  beat_t       owed_beats[$];
  logic [7:0]  sys_tick, usr_tick;
  logic [47:0] now_t, idle_t;
  logic        held[Depth];
  logic [47:0] due_at[Depth];
  logic [2:0]  ev_kind[Depth];
  logic [3:0]  ev_hnd[Depth];
  logic [31:0] ev_arg[Depth];
  logic [7:0]  rank[Depth];
  logic        stopped;
  int          errs;

  function automatic logic [47:0] clamp_sum(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? TimeMax : s[47:0];
  endfunction

  function automatic int soonest();
    int best;
    best = -1;
    for (int i = 0; i < Depth; i++)
      if (held[i] && (best < 0 || due_at[i] < due_at[best] ||
          (due_at[i] == due_at[best] && rank[i] < rank[best])))
        best = i;
    return best;
  endfunction

  function automatic int held_count();
    int n;
    n = 0;
    for (int i = 0; i < Depth; i++) n += held[i];
    return n;
  endfunction

  task automatic owe(logic fired, int s, logic [1:0] st, logic last);
    beat_t b;
    b = '0;
    b.fired = fired;
    if (fired) begin
      b.kind = ev_kind[s]; b.hnd = ev_hnd[s]; b.arg = ev_arg[s]; b.ftime = due_at[s];
    end
    b.st = st; b.now = now_t; b.idle = idle_t; b.last = last;
    owed_beats.push_back(b);
  endtask

  // Fire due events in order; while idling, hold a lone timer back.
  task automatic fire_due(logic idling);
    int s;
    forever begin
      s = soonest();
      if (s < 0 || due_at[s] > now_t) break;
      if (idling && held_count() == 1 && ev_kind[s] == KindTimer) break;
      owe(1'b1, s, StOk, 1'b0);
      held[s] = 1'b0;
    end
  endtask

  task automatic predict_item(cmd_e cmd, logic [19:0] dly, logic [2:0] kd,
                              logic [3:0] hd, logic [31:0] arg, logic um);
    int          s, free;
    logic [1:0]  st;
    logic [47:0] due;
    logic [8:0]  rk;
    st = StOk;
    if (stopped) begin
      owe(1'b0, 0, StHalted, 1'b1);
      return;
    end
    case (cmd)
      CmdSched: begin
        if (dly == 0) st = StZero;
        else begin
          free = -1;
          for (int i = Depth - 1; i >= 0; i--) if (!held[i]) free = i;
          if (free < 0) st = StFull;
          else begin
            due = clamp_sum(now_t, {28'd0, dly});
            rk = 0;
            for (int i = 0; i < Depth; i++)
              if (held[i] && due_at[i] == due && {1'b0, rank[i]} + 9'd1 > rk)
                rk = {1'b0, rank[i]} + 9'd1;
            held[free] = 1'b1; due_at[free] = due; rank[free] = rk[7:0];
            ev_kind[free] = kd; ev_hnd[free] = hd; ev_arg[free] = arg;
          end
        end
      end
      CmdTick: begin
        now_t = clamp_sum(now_t, {40'd0, um ? usr_tick : sys_tick});
        fire_due(1'b0);
      end
      CmdIdle: begin
        s = soonest();
        if (s < 0) begin
          stopped = 1'b1; st = StHalted;
        end else begin
          if (due_at[s] > now_t) begin
            idle_t = clamp_sum(idle_t, due_at[s] - now_t);
            now_t = due_at[s];
          end
          if (held_count() == 1 && ev_kind[s] == KindTimer) begin
            stopped = 1'b1; st = StHalted;
          end else fire_due(1'b1);
        end
      end
      default: ;
    endcase
    owe(1'b0, 0, st, 1'b1);
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: result %s got %0h want %0h", $realtime, what, got, want);
    errs++;
  endtask

  task automatic compare_beat();
    beat_t w;
    if (owed_beats.size() == 0) begin
      report("beat with nothing owed, status", status_i, 0);
      return;
    end
    w = owed_beats.pop_front();
    if (event_fired_i !== w.fired) report("event_fired", event_fired_i, w.fired);
    if (fired_kind_i !== w.kind) report("fired_kind", fired_kind_i, w.kind);
    if (fired_handler_i !== w.hnd) report("fired_handler", fired_handler_i, w.hnd);
    if (fired_argument_i !== w.arg) report("fired_argument", fired_argument_i, w.arg);
    if (fire_time_i !== w.ftime) report("fire_time", fire_time_i, w.ftime);
    if (status_i !== w.st) report("status", status_i, w.st);
    if (now_time_i !== w.now) report("now_time", now_time_i, w.now);
    if (idle_time_i !== w.idle) report("idle_time", idle_time_i, w.idle);
    if (last_i !== w.last) report("last", last_i, w.last);
  endtask

  initial begin
    errs = 0; stopped = 1'b0; sys_tick = 8'd10; usr_tick = 8'd1;
    now_t = '0; idle_t = '0;
    for (int i = 0; i < Depth; i++) held[i] = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgSysTick) sys_tick = cfg_data_i;
        else usr_tick = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) compare_beat();
      if (in_valid_i && !in_stall_i)
        predict_item(cmd_e'(cmd_i), delay_i, kind_i, handler_id_i, argument_i, user_mode_i);
    end
    mismatches_o  <= errs;
    beats_owed_o  <= owed_beats.size();
    events_held_o <= held_count();
    halted_o      <= stopped;
    lone_timer_o  <= held_count() == 1 && soonest() >= 0 && ev_kind[soonest()] == KindTimer;
  end

endmodule

FILE: tb/sv/timed_event_queue_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the timed event queue; all prediction and
// comparison lives in the checker instance.
module timed_event_queue_tb;
  import teq_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int SettleCycles  = 60;

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        cfg_ready_o;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  cmd_i;
  logic [19:0] delay_i;
  logic [2:0]  kind_i;
  logic [3:0]  handler_id_i;
  logic [31:0] argument_i;
  logic        user_mode_i;
  logic        out_valid_o, out_stall_i;
  logic        event_fired_o, last_o;
  logic [2:0]  fired_kind_o;
  logic [3:0]  fired_handler_o;
  logic [31:0] fired_argument_o;
  logic [47:0] fire_time_o, now_time_o, idle_time_o;
  logic [1:0]  status_o;

  int   mismatches, beats_owed, events_held;
  logic lone_timer, halted;
  int   cyc, quiet_cycles, hold_left;
  logic sender_busy;   // when low, the sender does not insert gaps

  timed_event_queue #(.QUEUE_DEPTH(16)) dut (.*);

  timed_event_queue_checker #(.Depth(16)) checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .cmd_i, .delay_i, .kind_i, .handler_id_i,
    .argument_i, .user_mode_i, .out_valid_i(out_valid_o), .out_stall_i,
    .event_fired_i(event_fired_o), .fired_kind_i(fired_kind_o),
    .fired_handler_i(fired_handler_o), .fired_argument_i(fired_argument_o),
    .fire_time_i(fire_time_o), .status_i(status_o), .now_time_i(now_time_o),
    .idle_time_i(idle_time_o), .last_i(last_o), .mismatches_o(mismatches),
    .beats_owed_o(beats_owed), .events_held_o(events_held),
    .lone_timer_o(lone_timer), .halted_o(halted)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, a quiet window with none, and a long periodic
  // hold-off so the output backs up into the input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      cyc <= 0;
      hold_left <= 0;
    end else begin
      cyc <= cyc + 1;
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (cyc % 5000 == 3000) begin
        out_stall_i <= 1'b1;
        hold_left <= 300;
      end else if (cyc % 5000 >= 1000 && cyc % 5000 < 1800) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= $urandom_range(0, 99) < 34;
      end
    end
  end

  // Watchdog: any accepted beat on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it.
  task automatic send_item(cmd_e cmd, logic [19:0] dly, logic [2:0] kd,
                           logic [3:0] hd, logic [31:0] arg, logic um);
    cmd_i <= cmd; delay_i <= dly; kind_i <= kd;
    handler_id_i <= hd; argument_i <= arg; user_mode_i <= um;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (sender_busy && $urandom_range(0, 99) < 34) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every owed result beat has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (beats_owed != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_index_i <= idx; cfg_data_i <= val; cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic sched(logic [19:0] dly, logic [2:0] kd);
    send_item(CmdSched, dly, kd, 4'($urandom), $urandom, 1'($urandom));
  endtask

  task automatic random_item();
    int          pick;
    logic [19:0] dly;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // Idle only on a settled store that cannot halt the block.
      drain();
      if (events_held > 0 && !lone_timer)
        send_item(CmdIdle, 20'($urandom), 3'($urandom), 4'($urandom), $urandom, 1'($urandom));
      else
        send_item(CmdTick, '0, '0, '0, '0, 1'($urandom));
    end else if (pick < 12) begin
      send_item(CmdNone, 20'($urandom), 3'($urandom), 4'($urandom), $urandom, 1'($urandom));
    end else if (pick < 55) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) dly = '0;
      else if (pick < 12) dly = 20'($urandom);
      else if (pick < 20) dly = 20'd7;   // shared due times, checks tie order
      else dly = 20'($urandom_range(1, 60));
      send_item(CmdSched, dly, 3'($urandom_range(0, 7)), 4'($urandom), $urandom,
                1'($urandom));
    end else begin
      send_item(CmdTick, 20'($urandom), 3'($urandom), 4'($urandom), $urandom,
                1'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = CfgSysTick; cfg_data_i = '0;
    in_valid_i = 1'b0; cmd_i = CmdNone; delay_i = '0; kind_i = '0;
    handler_id_i = '0; argument_i = '0; user_mode_i = 1'b0;
    sender_busy = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, zero delay, ties, timers, odd kinds, full store.
    send_item(CmdSched, 20'hFFFFF, 3'd7, 4'hF, 32'hFFFF_FFFF, 1'b1);
    send_item(CmdSched, 20'd0, 3'd1, 4'd0, 32'd0, 1'b0);
    send_item(CmdSched, 20'd5, 3'd1, 4'd1, 32'h1111_1111, 1'b0);
    send_item(CmdSched, 20'd5, 3'd2, 4'd2, 32'h2222_2222, 1'b0);
    send_item(CmdSched, 20'd5, 3'd6, 4'd3, 32'h3333_3333, 1'b0);
    send_item(CmdSched, 20'd3, KindTimer, 4'd4, 32'h4444_4444, 1'b0);
    send_item(CmdTick, '0, '0, '0, '0, 1'b0);
    send_item(CmdTick, '0, '0, '0, '0, 1'b1);
    send_item(CmdNone, 20'hFFFFF, 3'd7, 4'hF, 32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 16; i++) sched(20'($urandom_range(20, 90)), 3'($urandom_range(0, 7)));
    drain();
    // Idle fires the earliest event, then keep idling the store down.
    while (events_held > 1 || (events_held == 1 && !lone_timer)) begin
      send_item(CmdIdle, '0, '0, '0, '0, 1'b0);
      drain();
    end

    // Random phases over several tick settings, extremes included.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin write_reg(CfgSysTick, 8'd1); write_reg(CfgUserTick, 8'd255); end
        2: begin write_reg(CfgSysTick, 8'd255); write_reg(CfgUserTick, 8'd1); end
        3: begin
          write_reg(CfgSysTick, 8'($urandom_range(1, 255)));
          write_reg(CfgUserTick, 8'($urandom_range(1, 255)));
        end
        default: ;
      endcase
      for (int n = 0; n < 115; n++) begin
        sender_busy = !(ph == 1 && n >= 30 && n < 90);
        random_item();
      end
      // Pause the sender until every owed beat is back.
      drain();
    end

    // Idle until the block halts, then confirm it stays halted.
    sender_busy = 1'b1;
    while (!halted) begin
      send_item(CmdIdle, '0, '0, '0, '0, 1'b0);
      drain();
    end
    write_reg(CfgSysTick, 8'd10);
    for (int n = 0; n < 6; n++) random_item();
    drain();
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatches == 0 && beats_owed == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
